// ===== sv/lfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfd_pkg
// shared types and constants of the lin frame deframer
// ----------------------------------------------------------------------------
package lfd_pkg;

   localparam int MAX_DATA_BYTES = 8;
   localparam int IDX_W          = $clog2(MAX_DATA_BYTES + 1);
   localparam int SLOT_W         = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
   localparam int BYTE_W         = 8;
   localparam int LEN_W          = 4;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 8;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_VALUE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECKSUM_MODE = 2'd2;

   // reset values of the registers
   localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h55;
   localparam logic [LEN_W-1:0]  LEN_RESET  = 4'd8;
   localparam logic              MODE_RESET = 1'b1;

   localparam logic MODE_CLASSIC  = 1'b0;
   localparam logic MODE_ENHANCED = 1'b1;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_PID  = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_value;
      logic [LEN_W-1:0]  data_length;
      logic              checksum_mode;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]                     frame_pid;
      logic [MAX_DATA_BYTES-1:0][BYTE_W-1:0] data;
      logic                                  checksum_ok;
      logic                                  fell_back_classic;
      logic                                  parity_ok;
   } rsp_type;

endpackage

// ===== sv/lfd_csr.sv =====
// ----------------------------------------------------------------------------
// lfd_csr
// configuration registers written through the csr port
// ----------------------------------------------------------------------------
module lfd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lfd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output lfd_pkg::cfg_type                cfg
);

   lfd_pkg::cfg_type cfg_ff;
   lfd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lfd_pkg::CSR_SYNC_VALUE:    cfg_in.sync_value    = csr_wdata[lfd_pkg::BYTE_W-1:0];
            lfd_pkg::CSR_DATA_LENGTH:   cfg_in.data_length   = csr_wdata[lfd_pkg::LEN_W-1:0];
            lfd_pkg::CSR_CHECKSUM_MODE: cfg_in.checksum_mode = csr_wdata[0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value    <= lfd_pkg::SYNC_RESET;
         cfg_ff.data_length   <= lfd_pkg::LEN_RESET;
         cfg_ff.checksum_mode <= lfd_pkg::MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/lfd_parser.sv =====
// ----------------------------------------------------------------------------
// lfd_parser
// frame state machine, data store, running checksums and frame checks
// ----------------------------------------------------------------------------
module lfd_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [lfd_pkg::BYTE_W-1:0]   rx_byte,
   input  lfd_pkg::cfg_type             cfg,
   output logic                         emit,
   output lfd_pkg::rsp_type             rsp
);

   lfd_pkg::phase_type               phase_ff, phase_in;
   logic [lfd_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic [lfd_pkg::BYTE_W-1:0]       pid_ff, pid_in;
   logic [lfd_pkg::BYTE_W-1:0]       enh_ff, enh_in;
   logic [lfd_pkg::BYTE_W-1:0]       cls_ff, cls_in;
   logic [lfd_pkg::BYTE_W-1:0]       store_ff [lfd_pkg::MAX_DATA_BYTES];
   logic [lfd_pkg::IDX_W-1:0]        len_eff;
   logic                             take_data;
   logic [lfd_pkg::BYTE_W-1:0]       enh_ck;
   logic [lfd_pkg::BYTE_W-1:0]       cls_ck;

   // ones' complement byte add
   function automatic logic [lfd_pkg::BYTE_W-1:0] eac_add(
      input logic [lfd_pkg::BYTE_W-1:0] a,
      input logic [lfd_pkg::BYTE_W-1:0] b
   );
      logic [lfd_pkg::BYTE_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[lfd_pkg::BYTE_W-1:0] + {{(lfd_pkg::BYTE_W-1){1'b0}}, s[lfd_pkg::BYTE_W]};
   endfunction

   function automatic logic parity_good(input logic [lfd_pkg::BYTE_W-1:0] pid);
      logic p0, p1;
      p0 = pid[0] ^ pid[1] ^ pid[2] ^ pid[4];
      p1 = ~(pid[1] ^ pid[3] ^ pid[4] ^ pid[5]);
      return (pid[6] == p0) && (pid[7] == p1);
   endfunction

   // clamp length into one to max
   always_comb begin
      priority if (cfg.data_length == '0) begin
         len_eff = lfd_pkg::IDX_W'(1);
      end else if (lfd_pkg::IDX_W'(cfg.data_length) > lfd_pkg::IDX_W'(lfd_pkg::MAX_DATA_BYTES)
                   || (lfd_pkg::LEN_W > lfd_pkg::IDX_W
                       && (cfg.data_length >> lfd_pkg::IDX_W) != '0)) begin
         len_eff = lfd_pkg::IDX_W'(lfd_pkg::MAX_DATA_BYTES);
      end else begin
         len_eff = lfd_pkg::IDX_W'(cfg.data_length);
      end
   end

   assign take_data = (idx_ff < len_eff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         unique case (phase_ff)
            lfd_pkg::PH_PID:  phase_in = lfd_pkg::PH_DATA;
            lfd_pkg::PH_DATA: phase_in = take_data ? lfd_pkg::PH_DATA : lfd_pkg::PH_HUNT;
            default:          phase_in = (rx_byte == cfg.sync_value) ? lfd_pkg::PH_PID
                                                                     : lfd_pkg::PH_HUNT;
         endcase
      end
   end

   // datapath next values
   always_comb begin
      idx_in = idx_ff;
      pid_in = pid_ff;
      enh_in = enh_ff;
      cls_in = cls_ff;
      if (step) begin
         unique case (phase_ff)
            lfd_pkg::PH_PID: begin
               pid_in = rx_byte;
               cls_in = '0;
               enh_in = rx_byte;
               idx_in = '0;
            end
            lfd_pkg::PH_DATA: begin
               if (take_data) begin
                  cls_in = eac_add(cls_ff, rx_byte);
                  enh_in = eac_add(enh_ff, rx_byte);
                  idx_in = idx_ff + lfd_pkg::IDX_W'(1);
               end else begin
                  idx_in = '0;
               end
            end
            default: begin
               idx_in = idx_ff;
            end
         endcase
      end
   end

   // result of the checksum byte
   assign emit   = (phase_ff == lfd_pkg::PH_DATA) && !take_data;
   assign enh_ck = ~enh_ff;
   assign cls_ck = ~cls_ff;

   always_comb begin
      rsp.frame_pid = pid_ff;
      for (int i = 0; i < lfd_pkg::MAX_DATA_BYTES; i++) begin
         rsp.data[i] = (lfd_pkg::IDX_W'(i) < idx_ff) ? store_ff[i] : '0;
      end
      if (cfg.checksum_mode == lfd_pkg::MODE_ENHANCED) begin
         rsp.checksum_ok       = (enh_ck == rx_byte) || (cls_ck == rx_byte);
         rsp.fell_back_classic = (enh_ck != rx_byte) && (cls_ck == rx_byte);
      end else begin
         rsp.checksum_ok       = (cls_ck == rx_byte);
         rsp.fell_back_classic = 1'b0;
      end
      rsp.parity_ok = parity_good(pid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lfd_pkg::PH_HUNT;
         idx_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pid_ff <= pid_in;
      enh_ff <= enh_in;
      cls_ff <= cls_in;
      if (step && phase_ff == lfd_pkg::PH_DATA && take_data) begin
         store_ff[idx_ff[lfd_pkg::SLOT_W-1:0]] <= rx_byte;
      end
   end

endmodule

// ===== sv/lfd_rsp_stage.sv =====
// ----------------------------------------------------------------------------
// lfd_rsp_stage
// result register with valid and ready toward the consumer
// ----------------------------------------------------------------------------
module lfd_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  lfd_pkg::rsp_type  rsp_next,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              free,
   output lfd_pkg::rsp_type  rsp
);

   logic             vld_ff, vld_in;
   lfd_pkg::rsp_type rsp_ff;

   assign free = !vld_ff || rsp_ready;

   always_comb begin
      priority if (load) begin
         vld_in = 1'b1;
      end else if (rsp_ready) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== sv/lin_frame_deframer.sv =====
// result path: the held checksum byte's frame result is loaded into the result register
// throughput: one byte per cycle; the input register takes a new byte every cycle while
//   bytes flow, and stalls only when a checksum byte meets a full, unread result register
// reset: synchronous, active high; registers return to sync 0x55, length 8, enhanced mode,
//   and the parser returns to hunting for sync with both channels empty
// ----------------------------------------------------------------------------
// lin_frame_deframer
// lin frame parser: sync hunt, pid, data bytes and checksum, with pid parity and
// classic / enhanced checksum checks
// ----------------------------------------------------------------------------
module lin_frame_deframer (
   input  logic                            clock,
   input  logic                            reset,
   // configuration writes
   input  logic                            csr_we,
   input  logic [lfd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lfd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // received bytes
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_rx_byte,
   // frame results
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_frame_pid,
   output logic [7:0]                      rsp_data_0,
   output logic [7:0]                      rsp_data_1,
   output logic [7:0]                      rsp_data_2,
   output logic [7:0]                      rsp_data_3,
   output logic [7:0]                      rsp_data_4,
   output logic [7:0]                      rsp_data_5,
   output logic [7:0]                      rsp_data_6,
   output logic [7:0]                      rsp_data_7,
   output logic                            rsp_checksum_ok,
   output logic                            rsp_fell_back_classic,
   output logic                            rsp_parity_ok
);

   lfd_pkg::cfg_type cfg;
   lfd_pkg::rsp_type rsp_next;
   lfd_pkg::rsp_type rsp_q;

   // input register holding one accepted byte
   logic                          in_vld_ff, in_vld_in;
   logic [lfd_pkg::BYTE_W-1:0]    in_byte_ff;

   logic emit;      // held byte is a checksum byte and produces a frame result
   logic out_free;  // result register can take a new frame this cycle
   logic advance;   // held byte is consumed by the parser this cycle

   lfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // a checksum byte waits for room in the result register, all others pass freely
   assign advance   = in_vld_ff && (!emit || out_free);
   assign req_ready = !in_vld_ff || advance;

   always_comb begin
      priority if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   lfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .emit    (emit),
      .rsp     (rsp_next)
   );

   lfd_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && emit),
      .rsp_next  (rsp_next),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .free      (out_free),
      .rsp       (rsp_q)
   );

   // unpack the frame result onto the ports
   assign rsp_frame_pid         = rsp_q.frame_pid;
   assign rsp_data_0            = rsp_q.data[0];
   assign rsp_data_1            = rsp_q.data[1];
   assign rsp_data_2            = rsp_q.data[2];
   assign rsp_data_3            = rsp_q.data[3];
   assign rsp_data_4            = rsp_q.data[4];
   assign rsp_data_5            = rsp_q.data[5];
   assign rsp_data_6            = rsp_q.data[6];
   assign rsp_data_7            = rsp_q.data[7];
   assign rsp_checksum_ok       = rsp_q.checksum_ok;
   assign rsp_fell_back_classic = rsp_q.fell_back_classic;
   assign rsp_parity_ok         = rsp_q.parity_ok;

endmodule

// ===== sv/lfd_checker.sv =====
// ----------------------------------------------------------------------------
// lfd_checker
// port level checks of the lin frame deframer, bound to the top level
// ----------------------------------------------------------------------------
module lfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_frame_pid,
   input logic       rsp_checksum_ok,
   input logic       rsp_fell_back_classic
);

   // a stalled frame result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_pid))
      else $error("stalled frame result changed");

   // a classic fallback is always a checksum match
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fell_back_classic |-> rsp_checksum_ok)
      else $error("fallback flagged without checksum match");

   // reset empties the result side
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // reset empties the input register, so a byte is taken at once
   assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready right after reset");

endmodule

bind lin_frame_deframer lfd_checker u_lfd_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_frame_pid         (rsp_frame_pid),
   .rsp_checksum_ok       (rsp_checksum_ok),
   .rsp_fell_back_classic (rsp_fell_back_classic)
);
